// ----- design/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants of the skinning engine
// Beat layouts, the internal command, configuration and sequencer codes.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int ELEMS_PER_BONE = 12;

  // Sequencer counts: twelve palette reads, then the pipeline drains.
  localparam logic [4:0] ISSUE_LAST = 5'd11;
  localparam logic [4:0] RUN_LAST   = 5'd15;

  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  localparam logic CFG_SKINNING_ENABLE = 1'b0;
  localparam logic CFG_NORMALS_PRESENT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [5:0]         bone_index;
    logic [3:0]         element_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [16:0]        weight;
    logic               last_influence;
  } lbs_in_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_norm_x;
    logic signed [31:0] out_norm_y;
    logic signed [31:0] out_norm_z;
  } lbs_out_t;

  typedef enum logic {
    CMD_WRITE,
    CMD_INFL
  } lbs_kind_t;

  typedef struct packed {
    lbs_kind_t          kind;
    logic               ignore;
    logic               zero_mat;
    logic [5:0]         bone;
    logic [3:0]         elem;
    logic signed [31:0] value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic [16:0]        weight;
    logic               last;
  } lbs_cmd_t;

  typedef struct packed {
    logic skin_en;
    logic norm_en;
  } lbs_cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } lbs_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    if (v > 64'sh00007fffffffffff) begin
      return 48'sh7fffffffffff;
    end else if (v < -64'sh0000800000000000) begin
      return 48'sh800000000000;
    end
    return v[47:0];
  endfunction

endpackage

// ----- design/lbs_front.sv -----
// ----------------------------------------------------------------------------
// lbs_front: input classification
// Turns an input beat into a command: clamps the weight and flags palette
// writes to drop and influences whose bone lies outside the palette.
// ----------------------------------------------------------------------------
module lbs_front #(
  parameter int MAX_BONES = 64
) (
  input  lbs_pkg::lbs_in_t  in_data,
  output lbs_pkg::lbs_cmd_t cmd
);
  import lbs_pkg::*;

  logic bone_ok;
  logic elem_ok;

  assign bone_ok = (32'(in_data.bone_index) < 32'(MAX_BONES));
  assign elem_ok = (32'(in_data.element_index) < 32'(ELEMS_PER_BONE));

  always_comb begin
    cmd.kind     = in_data.mode ? CMD_INFL : CMD_WRITE;
    cmd.ignore   = !(bone_ok && elem_ok);
    cmd.zero_mat = !bone_ok;
    cmd.bone     = in_data.bone_index;
    cmd.elem     = in_data.element_index;
    cmd.value    = in_data.matrix_value;
    cmd.pos_x    = in_data.pos_x;
    cmd.pos_y    = in_data.pos_y;
    cmd.pos_z    = in_data.pos_z;
    cmd.norm_x   = in_data.norm_x;
    cmd.norm_y   = in_data.norm_y;
    cmd.norm_z   = in_data.norm_z;
    cmd.weight   = (in_data.weight > WEIGHT_ONE) ? WEIGHT_ONE : in_data.weight;
    cmd.last     = in_data.last_influence;
  end

endmodule

// ----- design/lbs_queue.sv -----
// ----------------------------------------------------------------------------
// lbs_queue: two-entry command queue
// Decouples the input side from the palette and arithmetic sequencer.
// ----------------------------------------------------------------------------
module lbs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lbs_pkg::lbs_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output lbs_pkg::lbs_cmd_t pop_data
);
  import lbs_pkg::*;

  lbs_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- design/lbs_engine.sv -----
// ----------------------------------------------------------------------------
// lbs_engine: palette memory and blend sequencer
// Reads the bone matrix one element per cycle, forms row sums, weights them
// and accumulates, then emits the skinned vertex into an output register.
// ----------------------------------------------------------------------------
module lbs_engine #(
  parameter int MAX_BONES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  lbs_pkg::lbs_cfg_t cfg,
  input  logic              q_valid,
  input  lbs_pkg::lbs_cmd_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output lbs_pkg::lbs_out_t out_data
);
  import lbs_pkg::*;

  localparam int DEPTH = MAX_BONES * ELEMS_PER_BONE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] mem [DEPTH];
  logic [31:0] mem_q;

  lbs_state_t state;
  lbs_state_t state_next;
  logic [4:0] cnt;
  lbs_cmd_t   cur;

  logic          rd_en;
  logic          emit_go;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;

  // Pipeline tags: element in flight at each stage.
  logic       v1, v2, v3, v4;
  logic [3:0] e1, e2;
  logic [1:0] row3, row4;

  logic signed [31:0] m_val;
  logic signed [32:0] mult_p;
  logic signed [32:0] mult_n;
  logic signed [65:0] prod_p, prod_n;
  logic signed [49:0] term_p, term_n;
  logic signed [50:0] rs_p, rs_n;
  logic signed [50:0] rsum_p, rsum_n;
  logic signed [31:0] tp, tn;
  logic signed [17:0] wt;
  logic signed [49:0] wp_p, wp_n;
  logic signed [47:0] pacc [3];
  logic signed [47:0] nacc [3];
  logic signed [48:0] psum, nsum;

  assign rd_addr = AW'(11'(cur.bone) * 11'(ELEMS_PER_BONE) + 11'(cnt[3:0]));
  assign wr_addr = AW'(11'(q_data.bone) * 11'(ELEMS_PER_BONE) + 11'(q_data.elem));
  assign wr_en   = q_pop && (q_data.kind == CMD_WRITE) && !q_data.ignore;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_data.kind == CMD_INFL) begin
          if (cfg.skin_en) begin
            state_next = ST_RUN;
          end else if (q_data.last) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_RUN: begin
        if (cnt == RUN_LAST) begin
          state_next = cur.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop   = 1'b0;
    rd_en   = 1'b0;
    emit_go = 1'b0;
    unique case (state)
      ST_IDLE: q_pop   = q_valid;
      ST_RUN:  rd_en   = (cnt <= ISSUE_LAST);
      ST_EMIT: emit_go = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 5'd0;
    end else begin
      state <= state_next;
      cnt   <= (state == ST_RUN) ? cnt + 5'd1 : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.kind == CMD_INFL) begin
      cur <= q_data;
    end
  end

  // Product stage: column 3 carries the translation, scaled so that the
  // shift below returns it unchanged.
  always_comb begin
    m_val = cur.zero_mat ? 32'sd0 : mem_q;
    case (e1[1:0])
      2'd0: begin
        mult_p = 33'(cur.pos_x);
        mult_n = 33'(cur.norm_x);
      end
      2'd1: begin
        mult_p = 33'(cur.pos_y);
        mult_n = 33'(cur.norm_y);
      end
      2'd2: begin
        mult_p = 33'(cur.pos_z);
        mult_n = 33'(cur.norm_z);
      end
      default: begin
        mult_p = 33'sd65536;
        mult_n = 33'sd0;
      end
    endcase
  end

  assign term_p = 50'(prod_p >>> 16);
  assign term_n = 50'(prod_n >>> 16);
  assign rsum_p = (e2[1:0] == 2'd0) ? 51'(term_p) : rs_p + 51'(term_p);
  assign rsum_n = (e2[1:0] == 2'd0) ? 51'(term_n) : rs_n + 51'(term_n);
  assign wt     = 18'($signed({1'b0, cur.weight}));
  assign psum   = 49'(pacc[row4]) + 49'(wp_p >>> 16);
  assign nsum   = 49'(nacc[row4]) + 49'(wp_n >>> 16);

  always_ff @(posedge clk) begin
    prod_p <= 66'(m_val) * 66'(mult_p);
    prod_n <= 66'(m_val) * 66'(mult_n);
    e2     <= e1;
    e1     <= cnt[3:0];
    if (v2) begin
      rs_p <= rsum_p;
      rs_n <= rsum_n;
    end
    tp   <= sat32(64'(rsum_p));
    tn   <= sat32(64'(rsum_n));
    row3 <= e2[3:2];
    wp_p <= 50'(tp) * 50'(wt);
    wp_n <= 50'(tn) * 50'(wt);
    row4 <= row3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      v3 <= v2 && (e2[1:0] == 2'd3);
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || emit_go) begin
      for (int i = 0; i < 3; i++) begin
        pacc[i] <= 48'sd0;
        nacc[i] <= 48'sd0;
      end
    end else if (v4) begin
      pacc[row4] <= sat48(64'(psum));
      if (cfg.norm_en) begin
        nacc[row4] <= sat48(64'(nsum));
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (cfg.skin_en) begin
        out_data.out_pos_x <= sat32(64'(pacc[0]));
        out_data.out_pos_y <= sat32(64'(pacc[1]));
        out_data.out_pos_z <= sat32(64'(pacc[2]));
        out_data.out_norm_x <= cfg.norm_en ? sat32(64'(nacc[0])) : 32'sd0;
        out_data.out_norm_y <= cfg.norm_en ? sat32(64'(nacc[1])) : 32'sd0;
        out_data.out_norm_z <= cfg.norm_en ? sat32(64'(nacc[2])) : 32'sd0;
      end else begin
        out_data.out_pos_x <= cur.pos_x;
        out_data.out_pos_y <= cur.pos_y;
        out_data.out_pos_z <= cur.pos_z;
        out_data.out_norm_x <= cfg.norm_en ? cur.norm_x : 32'sd0;
        out_data.out_norm_y <= cfg.norm_en ? cur.norm_y : 32'sd0;
        out_data.out_norm_z <= cfg.norm_en ? cur.norm_z : 32'sd0;
      end
    end
  end

  // The pipeline is empty whenever the sequencer is not running.
  a_pipe_drained: assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN |-> !(v1 || v2 || v3 || v4))
    else $error("blend pipeline busy outside a run");

  // A vertex is only emitted for an influence marked last.
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> cur.last)
    else $error("emission without a last influence");

  // Emission leaves the accumulators cleared.
  a_acc_clear: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (pacc[0] == 48'sd0 && pacc[1] == 48'sd0 && pacc[2] == 48'sd0 &&
                 nacc[0] == 48'sd0 && nacc[1] == 48'sd0 && nacc[2] == 48'sd0))
    else $error("accumulators not cleared after emission");

endmodule

// ----- design/linear_blend_skinning.sv -----
// Flow: an enabled influence leaves the queue once the engine is idle, then runs
// twelve palette reads through a four-stage pipeline; for a last influence the
// engine then waits in the emit state until the output register can take it.
// No new command is popped until the current influence is done; palette writes
// and pass-through beats are taken in idle, a last pass-through beat then emits.
// Reset clears control, accumulators and config (both enables set), not the palette.
// ----------------------------------------------------------------------------
// linear_blend_skinning: vertex skinning engine
// Front classifier, a two-entry command queue and the blend engine.
// ----------------------------------------------------------------------------
module linear_blend_skinning #(
  parameter int MAX_BONES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  lbs_pkg::lbs_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lbs_pkg::lbs_out_t out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic             cfg_data
);
  import lbs_pkg::*;

  lbs_cfg_t cfg;
  lbs_cmd_t cmd;
  lbs_cmd_t q_data;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skin_en <= 1'b1;
      cfg.norm_en <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKINNING_ENABLE: cfg.skin_en <= cfg_data;
        CFG_NORMALS_PRESENT: cfg.norm_en <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
    .in_data (in_data),
    .cmd     (cmd)
  );

  lbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  lbs_engine #(.MAX_BONES(MAX_BONES)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
